// File: rtl/pcd_pkg.sv
// Shared constants for the point-to-cylinder distance filter.
// Used by the divider, the square-root pipeline and the top level; no dependencies.
package pcd_pkg;

  // Width of the distance result and of the squared-distance quotient.
  localparam int DIST_W = 32;
  localparam int QB     = 2 * DIST_W;

  // Radius and tolerance registers.
  localparam int RAD_W = 31;

  // Register map, one index per configuration register.
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_ORG_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORG_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ORG_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_DIR_X = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Y = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_DIR_Z = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_TOL    = 3'd7;

  // Reset value of the axis z component (1.0 in Q16.16).
  localparam int DIR_Z_RESET = 65536;

  // Bit positions in the result tuser.
  localparam int FLAG_KEEP  = 0;
  localparam int FLAG_DEGEN = 1;
  localparam int FLAG_W     = 2;

endpackage

// File: rtl/pcd_geom.sv
// Front end: offset from the axis origin, cross product with the axis direction,
// squared cross magnitude and squared direction length. Seven register stages; uses pcd_pkg.
module pcd_geom #(
  parameter int W = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic signed [W-1:0]   pt_x,
  input  logic signed [W-1:0]   pt_y,
  input  logic signed [W-1:0]   pt_z,
  input  logic signed [W-1:0]   org_x,
  input  logic signed [W-1:0]   org_y,
  input  logic signed [W-1:0]   org_z,
  input  logic signed [W-1:0]   dir_x,
  input  logic signed [W-1:0]   dir_y,
  input  logic signed [W-1:0]   dir_z,
  output logic                  out_valid,
  output logic [3*W-1:0]        out_pt,
  output logic [4*W+3:0]        out_c2,
  output logic [2*W+1:0]        out_d2,
  output logic                  out_degen
);
  import pcd_pkg::*;

  localparam int NST = 7;
  localparam int PW  = 2 * W + 1;   // signed product of offset and direction
  localparam int CW  = 2 * W + 2;   // signed cross term
  localparam int MW  = 2 * W + 1;   // cross term magnitude
  localparam int LW  = W + 1;       // low part of the magnitude split
  localparam int HW  = MW - LW;     // high part
  localparam int SW  = 2 * MW;      // square of one cross term
  localparam int C2W = SW + 2;
  localparam int DW  = 2 * W + 2;

  logic [NST-1:0]        vld_r;
  logic [3*W-1:0]        pt_r [NST];

  logic signed [W:0]     vx_r, vy_r, vz_r;
  logic [2*W-1:0]        dsq_r [3];
  logic signed [PW-1:0]  pyz_r, pzy_r, pzx_r, pxz_r, pxy_r, pyx_r;
  logic signed [CW-1:0]  crs_r [3];
  logic [MW-1:0]         mag_r [3];
  logic [2*HW-1:0]       hh_r [3];
  logic [HW+LW-1:0]      hl_r [3];
  logic [2*LW-1:0]       ll_r [3];
  logic [SW-1:0]         sq_r [3];
  logic [C2W-1:0]        c2_r;
  logic [DW-1:0]         d2_r [6];   // stages two to seven
  logic                  dg_r [4];   // stages four to seven

  logic signed [CW-1:0]  crs_nxt [3];
  logic [MW-1:0]         mag_nxt [3];
  logic [SW-1:0]         sq_nxt [3];

  always_comb begin
    crs_nxt[0] = CW'(pyz_r) - CW'(pzy_r);
    crs_nxt[1] = CW'(pzx_r) - CW'(pxz_r);
    crs_nxt[2] = CW'(pxy_r) - CW'(pyx_r);
    for (int a = 0; a < 3; a++) begin
      // The most negative cross term cannot occur, so the magnitude fits MW bits.
      mag_nxt[a] = crs_r[a][CW-1] ? MW'(~crs_r[a] + CW'(1)) : MW'(crs_r[a]);
      sq_nxt[a]  = (SW'(hh_r[a]) << (2 * LW)) + (SW'(hl_r[a]) << (LW + 1)) + SW'(ll_r[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NST-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r[0] <= {pt_z, pt_y, pt_x};
      for (int s = 1; s < NST; s++) begin
        pt_r[s] <= pt_r[s-1];
      end

      // Stage 1: offset from the origin and squared direction components.
      vx_r <= (W+1)'(pt_x) - (W+1)'(org_x);
      vy_r <= (W+1)'(pt_y) - (W+1)'(org_y);
      vz_r <= (W+1)'(pt_z) - (W+1)'(org_z);
      dsq_r[0] <= (2*W)'(dir_x * dir_x);
      dsq_r[1] <= (2*W)'(dir_y * dir_y);
      dsq_r[2] <= (2*W)'(dir_z * dir_z);

      // Stage 2: the six products of the cross product.
      pyz_r <= vy_r * dir_z;
      pzy_r <= vz_r * dir_y;
      pzx_r <= vz_r * dir_x;
      pxz_r <= vx_r * dir_z;
      pxy_r <= vx_r * dir_y;
      pyx_r <= vy_r * dir_x;
      d2_r[0] <= DW'(dsq_r[0]) + DW'(dsq_r[1]) + DW'(dsq_r[2]);

      // Stage 3: cross terms.
      for (int a = 0; a < 3; a++) begin
        crs_r[a] <= crs_nxt[a];
      end
      d2_r[1] <= d2_r[0];

      // Stage 4: magnitudes.
      for (int a = 0; a < 3; a++) begin
        mag_r[a] <= mag_nxt[a];
      end
      d2_r[2] <= d2_r[1];
      dg_r[0] <= (d2_r[1] == '0);

      // Stage 5: partial products of each square.
      for (int a = 0; a < 3; a++) begin
        hh_r[a] <= mag_r[a][MW-1:LW] * mag_r[a][MW-1:LW];
        hl_r[a] <= mag_r[a][MW-1:LW] * mag_r[a][LW-1:0];
        ll_r[a] <= mag_r[a][LW-1:0] * mag_r[a][LW-1:0];
      end
      d2_r[3] <= d2_r[2];
      dg_r[1] <= dg_r[0];

      // Stage 6: squares.
      for (int a = 0; a < 3; a++) begin
        sq_r[a] <= sq_nxt[a];
      end
      d2_r[4] <= d2_r[3];
      dg_r[2] <= dg_r[1];

      // Stage 7: squared cross magnitude.
      c2_r <= C2W'(sq_r[0]) + C2W'(sq_r[1]) + C2W'(sq_r[2]);
      d2_r[5] <= d2_r[4];
      dg_r[3] <= dg_r[2];
    end
  end

  assign out_valid = vld_r[NST-1];
  assign out_pt    = pt_r[NST-1];
  assign out_c2    = c2_r;
  assign out_d2    = d2_r[5];
  assign out_degen = dg_r[3];

endmodule

// File: rtl/pcd_div.sv
// Pipelined restoring divider: squared cross magnitude over squared direction length,
// one quotient bit per stage, quotient saturated to 64 bits. Uses pcd_pkg.
module pcd_div #(
  parameter int C2W    = 132,
  parameter int DW     = 66,
  parameter int SIDE_W = 97
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [C2W-1:0]           in_c2,
  input  logic [DW-1:0]            in_d2,
  input  logic [SIDE_W-1:0]        in_side,
  output logic                     out_valid,
  output logic [pcd_pkg::QB-1:0]   out_quo,
  output logic [SIDE_W-1:0]        out_side
);
  import pcd_pkg::*;

  localparam int R0W  = C2W - QB;
  localparam int CMPW = (R0W > DW) ? R0W : DW;

  logic [QB:0]        vld_r;
  logic [DW-1:0]      rem_r  [QB+1];
  logic [QB-1:0]      quo_r  [QB+1];
  logic [QB-1:0]      low_r  [QB+1];
  logic [DW-1:0]      d2_r   [QB+1];
  logic               ovf_r  [QB+1];
  logic [SIDE_W-1:0]  side_r [QB+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[QB-1:0], in_valid};
    end
  end

  // Entry stage: a top part not below the divisor means a quotient of 2^64 or more.
  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= DW'(in_c2[C2W-1:QB]);
      ovf_r[0]  <= CMPW'(in_c2[C2W-1:QB]) >= CMPW'(in_d2);
      quo_r[0]  <= '0;
      low_r[0]  <= in_c2[QB-1:0];
      d2_r[0]   <= in_d2;
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 0; s < QB; s++) begin : g_step
    logic [DW:0] trial;
    logic        ge;

    always_comb begin
      trial = {rem_r[s], low_r[s][QB-1]};
      ge    = trial >= (DW+1)'(d2_r[s]);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= ge ? DW'(trial - (DW+1)'(d2_r[s])) : DW'(trial);
        quo_r[s+1]  <= {quo_r[s][QB-2:0], ge};
        low_r[s+1]  <= low_r[s] << 1;
        d2_r[s+1]   <= d2_r[s];
        ovf_r[s+1]  <= ovf_r[s];
        side_r[s+1] <= side_r[s];
      end
    end
  end

  assign out_valid = vld_r[QB];
  assign out_quo   = ovf_r[QB] ? '1 : quo_r[QB];
  assign out_side  = side_r[QB];

endmodule

// File: rtl/pcd_sqrt.sv
// Pipelined digit-by-digit integer square root of the 64-bit quotient,
// one root bit per stage. Uses pcd_pkg.
module pcd_sqrt #(
  parameter int SIDE_W = 97
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [pcd_pkg::QB-1:0]       in_rad,
  input  logic [SIDE_W-1:0]            in_side,
  output logic                         out_valid,
  output logic [pcd_pkg::DIST_W-1:0]   out_root,
  output logic [SIDE_W-1:0]            out_side
);
  import pcd_pkg::*;

  // The remainder never exceeds twice the partial root.
  localparam int RW = DIST_W + 2;

  logic [DIST_W:0]      vld_r;
  logic [QB-1:0]        rad_r  [DIST_W+1];
  logic [RW-1:0]        rem_r  [DIST_W+1];
  logic [DIST_W-1:0]    root_r [DIST_W+1];
  logic [SIDE_W-1:0]    side_r [DIST_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[DIST_W-1:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rad_r[0]  <= in_rad;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  for (genvar j = 0; j < DIST_W; j++) begin : g_step
    logic [RW+1:0] acc;
    logic [RW+1:0] trial;
    logic          ge;

    always_comb begin
      acc   = {rem_r[j], rad_r[j][QB-1:QB-2]};
      trial = (RW+2)'({root_r[j], 2'b01});
      ge    = acc >= trial;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j+1]  <= ge ? RW'(acc - trial) : RW'(acc);
        root_r[j+1] <= {root_r[j][DIST_W-2:0], ge};
        rad_r[j+1]  <= rad_r[j] << 2;
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign out_valid = vld_r[DIST_W];
  assign out_root  = root_r[DIST_W];
  assign out_side  = side_r[DIST_W];

endmodule

// File: rtl/point_to_cylinder_distance_filter.sv
// Point-to-cylinder distance filter: 7 geometry stages, 65 divider stages,
// 33 square-root stages and 1 output register from input to result.
// Throughput one item per cycle; the whole pipeline advances together and holds while
// a result waits at the output. Synchronous active-low reset clears the valid bits
// and the configuration registers; data registers are not reset.
// Depends on pcd_pkg, pcd_geom, pcd_div and pcd_sqrt.
module point_to_cylinder_distance_filter #(
  parameter int COORD_BITS = 32
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  // Input items.
  input  logic                                              in_tvalid,
  output logic                                              in_tready,
  // pt_x, pt_y, pt_z from the lowest bit up, zero padding on top
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]                 in_tdata,
  // Result items.
  output logic                                              out_tvalid,
  input  logic                                              out_tready,
  // res_x, res_y, res_z, axis_distance from the lowest bit up, zero padding on top
  output logic [((3*COORD_BITS+pcd_pkg::DIST_W+7)/8)*8-1:0] out_tdata,
  // keep, degenerate from the lowest bit up
  output logic [pcd_pkg::FLAG_W-1:0]                        out_tuser,
  // Configuration port.
  input  logic                                              psel,
  input  logic                                              penable,
  input  logic                                              pwrite,
  input  logic [pcd_pkg::REG_IDX_W+(COORD_BITS>32 ? 3 : 2)-1:0] paddr,
  input  logic [(COORD_BITS>32 ? 64 : 32)-1:0]              pwdata,
  output logic [(COORD_BITS>32 ? 64 : 32)-1:0]              prdata,
  output logic                                              pready
);
  import pcd_pkg::*;

  localparam int W        = COORD_BITS;
  localparam int C2W      = 4 * W + 4;
  localparam int DW       = 2 * W + 2;
  localparam int SIDE_W   = 3 * W + 1;
  localparam int OUT_TW   = ((3 * W + DIST_W + 7) / 8) * 8;
  localparam int CFG_DW   = (W > 32) ? 64 : 32;
  localparam int ADDR_LSB = (W > 32) ? 3 : 2;
  localparam int CFG_AW   = REG_IDX_W + ADDR_LSB;

  // Configuration registers.
  logic signed [W-1:0] org_x_r, org_y_r, org_z_r;
  logic signed [W-1:0] dir_x_r, dir_y_r, dir_z_r;
  logic [RAD_W-1:0]    radius_r, tol_r;

  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[CFG_AW-1:ADDR_LSB];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      org_x_r  <= '0;
      org_y_r  <= '0;
      org_z_r  <= '0;
      dir_x_r  <= '0;
      dir_y_r  <= '0;
      dir_z_r  <= W'(DIR_Z_RESET);
      radius_r <= '0;
      tol_r    <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ORG_X:  org_x_r  <= pwdata[W-1:0];
        REG_ORG_Y:  org_y_r  <= pwdata[W-1:0];
        REG_ORG_Z:  org_z_r  <= pwdata[W-1:0];
        REG_DIR_X:  dir_x_r  <= pwdata[W-1:0];
        REG_DIR_Y:  dir_y_r  <= pwdata[W-1:0];
        REG_DIR_Z:  dir_z_r  <= pwdata[W-1:0];
        REG_RADIUS: radius_r <= pwdata[RAD_W-1:0];
        REG_TOL:    tol_r    <= pwdata[RAD_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ORG_X:  prdata = CFG_DW'($unsigned(org_x_r));
      REG_ORG_Y:  prdata = CFG_DW'($unsigned(org_y_r));
      REG_ORG_Z:  prdata = CFG_DW'($unsigned(org_z_r));
      REG_DIR_X:  prdata = CFG_DW'($unsigned(dir_x_r));
      REG_DIR_Y:  prdata = CFG_DW'($unsigned(dir_y_r));
      REG_DIR_Z:  prdata = CFG_DW'($unsigned(dir_z_r));
      REG_RADIUS: prdata = CFG_DW'(radius_r);
      REG_TOL:    prdata = CFG_DW'(tol_r);
    endcase
  end

  // The pipeline moves whenever the output register is free or being emptied.
  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic                geo_valid;
  logic [3*W-1:0]      geo_pt;
  logic [C2W-1:0]      geo_c2;
  logic [DW-1:0]       geo_d2;
  logic                geo_degen;

  pcd_geom #(.W(W)) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .pt_x      (in_tdata[W-1:0]),
    .pt_y      (in_tdata[2*W-1:W]),
    .pt_z      (in_tdata[3*W-1:2*W]),
    .org_x     (org_x_r),
    .org_y     (org_y_r),
    .org_z     (org_z_r),
    .dir_x     (dir_x_r),
    .dir_y     (dir_y_r),
    .dir_z     (dir_z_r),
    .out_valid (geo_valid),
    .out_pt    (geo_pt),
    .out_c2    (geo_c2),
    .out_d2    (geo_d2),
    .out_degen (geo_degen)
  );

  logic              div_valid;
  logic [QB-1:0]     div_quo;
  logic [SIDE_W-1:0] div_side;

  pcd_div #(.C2W(C2W), .DW(DW), .SIDE_W(SIDE_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (geo_valid),
    .in_c2     (geo_c2),
    .in_d2     (geo_d2),
    .in_side   ({geo_degen, geo_pt}),
    .out_valid (div_valid),
    .out_quo   (div_quo),
    .out_side  (div_side)
  );

  logic              sq_valid;
  logic [DIST_W-1:0] sq_root;
  logic [SIDE_W-1:0] sq_side;

  pcd_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (div_valid),
    .in_rad    (div_quo),
    .in_side   (div_side),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_side)
  );

  // Output register with the radius test.
  logic              sq_degen;
  logic [DIST_W-1:0] dist_nxt;
  logic [DIST_W-1:0] diff_nxt;
  logic              keep_nxt;

  logic [3*W-1:0]    pt_r;
  logic [DIST_W-1:0] dist_r;
  logic              keep_r;
  logic              degen_r;

  always_comb begin
    sq_degen = sq_side[SIDE_W-1];
    dist_nxt = sq_degen ? '0 : sq_root;
    diff_nxt = (dist_nxt > DIST_W'(radius_r)) ? dist_nxt - DIST_W'(radius_r)
                                              : DIST_W'(radius_r) - dist_nxt;
    keep_nxt = !sq_degen && (diff_nxt < DIST_W'(tol_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pt_r    <= sq_side[3*W-1:0];
      dist_r  <= dist_nxt;
      keep_r  <= keep_nxt;
      degen_r <= sq_degen;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TW'({dist_r, pt_r});
  assign out_tuser  = {degen_r, keep_r};

`ifndef ASSERT_OFF
  a_degen_clears: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && degen_r |-> !keep_r && (dist_r == '0))
    else $error("degenerate axis result carries keep or a distance");

  a_keep_needs_tol: assert property (@(posedge clk) disable iff (!rst_n)
      out_valid_r && keep_r |-> (tol_r != '0))
    else $error("point kept with zero tolerance");

  a_reset_empty: assert property (@(posedge clk)
      !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");
`endif

endmodule

// File: test/pcd_checker.sv
// Checker for the point-to-cylinder distance filter: follows configuration writes,
// predicts each result from the accepted point and compares it with the output stream.
// Depends on pcd_pkg for the register indexes and the flag positions.
module pcd_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [95:0]  in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [127:0] out_tdata,
  input  logic [1:0]   out_tuser,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  input  logic         pready,
  output int           errors,
  output int           pending
);
  import pcd_pkg::*;

  typedef struct {
    logic [31:0] x, y, z, distance;
    logic        keep, degen;
  } cyl_result_t;

  cyl_result_t expected_q[$];

  logic signed [31:0] org_x, org_y, org_z, dir_x, dir_y, dir_z;
  logic [30:0]        radius, tol;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h, expected %h", what, got, want);
    errors++;
  endtask

  function automatic cyl_result_t predict(input logic signed [31:0] px, py, pz);
    cyl_result_t r;
    logic signed [259:0] vx, vy, vz, cx, cy, cz;
    logic [259:0] d2, c2, sq;
    logic [63:0] cand;
    logic [31:0] root;
    logic [31:0] diff;
    vx = px - org_x;
    vy = py - org_y;
    vz = pz - org_z;
    d2 = dir_x * dir_x + dir_y * dir_y + dir_z * dir_z;
    r.x = px; r.y = py; r.z = pz;
    r.distance = '0; r.keep = 1'b0; r.degen = 1'b0;
    if (d2 == 0) begin
      r.degen = 1'b1;
    end else begin
      cx = vy * dir_z - vz * dir_y;
      cy = vz * dir_x - vx * dir_z;
      cz = vx * dir_y - vy * dir_x;
      c2 = cx * cx + cy * cy + cz * cz;
      root = '0;
      for (int b = 31; b >= 0; b--) begin
        cand = {32'd0, root | (32'd1 << b)};
        sq = cand * cand;
        sq = sq * d2;
        if (sq <= c2) root = cand[31:0];
      end
      diff = (root > {1'b0, radius}) ? root - {1'b0, radius} : {1'b0, radius} - root;
      r.distance = root;
      r.keep = diff < {1'b0, tol};
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    cyl_result_t e;
    if (!rst_n) begin
      org_x <= '0; org_y <= '0; org_z <= '0;
      dir_x <= '0; dir_y <= '0; dir_z <= DIR_Z_RESET;
      radius <= '0; tol <= '0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_ORG_X:  org_x  <= pwdata;
          REG_ORG_Y:  org_y  <= pwdata;
          REG_ORG_Z:  org_z  <= pwdata;
          REG_DIR_X:  dir_x  <= pwdata;
          REG_DIR_Y:  dir_y  <= pwdata;
          REG_DIR_Z:  dir_z  <= pwdata;
          REG_RADIUS: radius <= pwdata[30:0];
          REG_TOL:    tol    <= pwdata[30:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_q.insert(expected_q.size(),
                          predict(in_tdata[31:0], in_tdata[63:32], in_tdata[95:64]));
      if (out_tvalid && out_tready) begin
        if (expected_q.size() == 0) begin
          report("unexpected result item", out_tdata[31:0], 32'd0);
        end else begin
          e = expected_q.pop_front();
          if (out_tdata[31:0] !== e.x) report("res_x", out_tdata[31:0], e.x);
          if (out_tdata[63:32] !== e.y) report("res_y", out_tdata[63:32], e.y);
          if (out_tdata[95:64] !== e.z) report("res_z", out_tdata[95:64], e.z);
          if (out_tdata[127:96] !== e.distance)
            report("axis_distance", out_tdata[127:96], e.distance);
          if (out_tuser[FLAG_KEEP] !== e.keep)
            report("keep", {31'd0, out_tuser[FLAG_KEEP]}, {31'd0, e.keep});
          if (out_tuser[FLAG_DEGEN] !== e.degen)
            report("degenerate", {31'd0, out_tuser[FLAG_DEGEN]}, {31'd0, e.degen});
        end
      end
    end
  end
endmodule

// File: test/tb.sv
// Top of the testbench for the point-to-cylinder distance filter: clock, reset, APB
// configuration, point stimulus and receiver back-pressure; pcd_checker does the checking.
// Depends on pcd_pkg, point_to_cylinder_distance_filter and pcd_checker.
module tb;
  import pcd_pkg::*;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_tvalid = 1'b0, in_tready;
  logic [95:0] in_tdata = '0;
  logic out_tvalid, out_tready = 1'b0;
  logic [127:0] out_tdata;
  logic [1:0] out_tuser;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;
  logic pready;
  int errors, pending;
  int cycles = 0;
  bit calm = 0, hold_req = 0;
  int hold_cnt = 0, idle_cnt = 0;

  // Current cylinder, kept here to aim points at its surface.
  logic signed [31:0] c_org[3];
  int  c_axis;
  logic [30:0] c_rad, c_tol;

  point_to_cylinder_distance_filter u_top (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  pcd_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .out_tvalid, .out_tready,
    .out_tdata, .out_tuser, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
    .errors, .pending
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 300000) begin
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req = 0;
      hold_cnt = 400;
      out_tready <= 1'b0;
    end else if (idle_cnt > 0) begin
      idle_cnt--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      idle_cnt = $urandom_range(0, 10);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Stops offering items, waits for the pipeline to drain, then loads a whole cylinder.
  task automatic set_cylinder(input logic [31:0] ox, oy, oz, dx, dy, dz, rad, tl);
    in_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    reg_write(REG_ORG_X, ox);
    reg_write(REG_ORG_Y, oy);
    reg_write(REG_ORG_Z, oz);
    reg_write(REG_DIR_X, dx);
    reg_write(REG_DIR_Y, dy);
    reg_write(REG_DIR_Z, dz);
    reg_write(REG_RADIUS, rad);
    reg_write(REG_TOL, tl);
    c_org[0] = ox; c_org[1] = oy; c_org[2] = oz;
    c_rad = rad[30:0]; c_tol = tl[30:0];
  endtask

  task automatic send_point(input logic [31:0] x, y, z);
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {z, y, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Mostly points close to the surface of an axis-aligned cylinder, some fully random.
  task automatic send_random_point();
    logic [31:0] p[3];
    int jit, a1, a2;
    if ($urandom_range(0, 3) == 0) begin
      p[0] = $urandom; p[1] = $urandom; p[2] = $urandom;
    end else begin
      jit = $signed($urandom_range(0, 2 * c_tol + 2)) - $signed(c_tol) - 1;
      a1 = (c_axis + 1) % 3;
      a2 = (c_axis + 2) % 3;
      p[c_axis] = $urandom;
      p[a1] = c_org[a1] + ($urandom_range(0, 1) ? c_rad + jit : -(c_rad + jit));
      p[a2] = c_org[a2] + $signed($urandom_range(0, 255)) - 128;
    end
    send_point(p[0], p[1], p[2]);
  endtask

  task automatic random_cylinder(input bit aligned);
    logic [31:0] d[3];
    logic [31:0] rad, tl;
    c_axis = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++)
      d[i] = aligned ? ((i == c_axis) ? $urandom_range(1, 1 << 20) * ($urandom_range(0, 1) ? 1 : -1)
                                      : 32'd0)
                     : $urandom;
    rad = $urandom_range(0, 1 << 24) | ($urandom_range(0, 1) << 31);
    tl = $urandom_range(1, 1 << 18);
    set_cylinder($signed($urandom_range(0, 1 << 22)) - (1 << 21),
                 $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                 $signed($urandom_range(0, 1 << 22)) - (1 << 21),
                 d[0], d[1], d[2], rad, tl);
  endtask

  initial begin
    c_org[0] = 0; c_org[1] = 0; c_org[2] = 0;
    c_axis = 2; c_rad = 0; c_tol = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset configuration: unit z axis, zero radius and tolerance, so nothing is kept.
    send_point(32'h0, 32'h0, 32'h0);
    send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_point(32'h0001_0000, 32'h0, 32'h1234_5678);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);

    // Line test with a tolerance: a point on the axis is kept.
    set_cylinder(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'h0, 32'h0000_0001);
    send_point(32'h0, 32'h0, 32'h5555_0000);
    send_point(32'h1, 32'h0, 32'h0);
    send_point(32'hFFFF_FFFF, 32'h0, 32'h0);

    // Exact radius hit and the strict tolerance boundary.
    set_cylinder(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0000_0003, 32'h0002_0000,
                 32'h0000_0010);
    send_point(32'h0002_0000, 32'h0, 32'h0);
    send_point(32'h0002_0010, 32'h0, 32'h0);
    send_point(32'h0002_000F, 32'h0, 32'h0);
    send_point(32'h0, 32'hFFFE_0000, 32'h7000_0000);

    // Extremes of every register; the stray top bit of radius and tolerance is ignored.
    set_cylinder(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    send_point(32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 50; i++) send_random_point();

    // Zero direction: degenerate, never kept.
    set_cylinder($urandom, $urandom, $urandom, 32'h0, 32'h0, 32'h0, $urandom, 32'h7FFF_FFFF);
    send_point(32'h0, 32'h0, 32'h0);
    for (int i = 0; i < 35; i++) send_random_point();

    // The long hold-off phase sends more items than the pipeline holds, so the input stalls.
    for (int ph = 0; ph < 6; ph++) begin
      random_cylinder(ph % 3 != 2);
      if (ph == 1) hold_req = 1;
      for (int i = 0; i < ((ph == 1) ? 140 : 50); i++) send_random_point();
    end

    // Last stretch without idling on either side.
    random_cylinder(1);
    calm = 1;
    for (int i = 0; i < 60; i++) send_random_point();
    in_tvalid <= 1'b0;

    while (pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end
endmodule
